@@ hw/rtl/mpc_pkg.sv @@
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared types, constants and the color palette of the escape-time colorer.
// ----------------------------------------------------------------------------
package mpc_pkg;

    localparam int MAX_ITER     = 500;
    localparam int PALETTE_SIZE = 16;
    localparam int COORD_W      = 32;
    localparam int FRAC_BITS    = 28;
    localparam int MAX_DIM      = 4096;

    localparam int IDX_W        = 12;
    localparam int SPAN_W       = 31;
    localparam int DIM_W        = 13;
    localparam int PROD_W       = 2 * COORD_W;
    localparam int DIV_N        = IDX_W + SPAN_W;
    localparam int ITER_W       = $clog2(MAX_ITER + 1);
    localparam int ESC_W        = 9;
    localparam int PAL_W        = $clog2(PALETTE_SIZE);
    localparam int CH_W         = 8;

    localparam int TDATA_IN_W   = 24;
    localparam int TDATA_OUT_W  = 48;
    localparam int APB_AW       = 5;
    localparam int APB_DW       = 32;
    localparam int REG_IDX_W    = 3;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ORIGIN_REAL  = 3'd0,
        REG_ORIGIN_IMAG  = 3'd1,
        REG_SPAN_REAL    = 3'd2,
        REG_SPAN_IMAG    = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_real;
        logic signed [COORD_W-1:0] origin_imag;
        logic [SPAN_W-1:0]         span_real;
        logic [SPAN_W-1:0]         span_imag;
        logic [DIM_W-1:0]          image_width;
        logic [DIM_W-1:0]          image_height;
    } cfg_t;

    typedef struct packed {
        logic [ESC_W-1:0] escape_count;
        logic             inside_set;
        logic [CH_W-1:0]  alpha;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
    } pix_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_MAP_START,
        ST_MAP_WAIT,
        ST_SQX,
        ST_SQY,
        ST_PXY,
        ST_UPD,
        ST_DONE
    } state_t;

    // color as {red, green, blue}
    function automatic logic [3*CH_W-1:0] palette(input logic [PAL_W-1:0] idx);
        logic [3*CH_W-1:0] rgb;
        case (idx)
            4'd0:    rgb = {8'd66,  8'd30,  8'd15};
            4'd1:    rgb = {8'd25,  8'd7,   8'd26};
            4'd2:    rgb = {8'd9,   8'd1,   8'd47};
            4'd3:    rgb = {8'd4,   8'd4,   8'd73};
            4'd4:    rgb = {8'd0,   8'd7,   8'd100};
            4'd5:    rgb = {8'd12,  8'd44,  8'd138};
            4'd6:    rgb = {8'd24,  8'd82,  8'd177};
            4'd7:    rgb = {8'd57,  8'd125, 8'd209};
            4'd8:    rgb = {8'd134, 8'd181, 8'd229};
            4'd9:    rgb = {8'd211, 8'd236, 8'd248};
            4'd10:   rgb = {8'd241, 8'd233, 8'd191};
            4'd11:   rgb = {8'd248, 8'd201, 8'd95};
            4'd12:   rgb = {8'd255, 8'd170, 8'd0};
            4'd13:   rgb = {8'd204, 8'd128, 8'd0};
            4'd14:   rgb = {8'd153, 8'd87,  8'd0};
            4'd15:   rgb = {8'd106, 8'd52,  8'd3};
            default: rgb = '0;
        endcase
        return rgb;
    endfunction

endpackage

@@ hw/rtl/mpc_regs.sv @@
// ----------------------------------------------------------------------------
// mpc_regs
// APB register file holding the view window and the image size.
// ----------------------------------------------------------------------------
module mpc_regs
    import mpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    reg_idx_t   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ORIGIN_REAL:  cfg_next.origin_real  = pwdata;
                REG_ORIGIN_IMAG:  cfg_next.origin_imag  = pwdata;
                REG_SPAN_REAL:    cfg_next.span_real    = pwdata[SPAN_W-1:0];
                REG_SPAN_IMAG:    cfg_next.span_imag    = pwdata[SPAN_W-1:0];
                REG_IMAGE_WIDTH:  cfg_next.image_width  = pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = pwdata[DIM_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ORIGIN_REAL:  prdata = cfg_reg.origin_real;
            REG_ORIGIN_IMAG:  prdata = cfg_reg.origin_imag;
            REG_SPAN_REAL:    prdata = {1'b0, cfg_reg.span_real};
            REG_SPAN_IMAG:    prdata = {1'b0, cfg_reg.span_imag};
            REG_IMAGE_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, cfg_reg.image_width};
            REG_IMAGE_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, cfg_reg.image_height};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_real  <= 32'hE000_0000;
            cfg_reg.origin_imag  <= 32'hEC00_0000;
            cfg_reg.span_real    <= 31'h2800_0000;
            cfg_reg.span_imag    <= 31'h2800_0000;
            cfg_reg.image_width  <= 13'd500;
            cfg_reg.image_height <= 13'd500;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/mpc_div.sv @@
// ----------------------------------------------------------------------------
// mpc_div
// Serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpc_div
    import mpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_N-1:0] dividend,
    input  logic [DIM_W-1:0] divisor,
    output logic             done,
    output logic [DIV_N-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_N);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DIM_W-1:0] rem_reg;
    logic [DIM_W-1:0] rem_next;
    logic [DIV_N-1:0] quo_reg;
    logic [DIV_N-1:0] quo_next;
    logic [DIM_W-1:0] dvs_reg;
    logic [DIM_W-1:0] dvs_next;
    logic [DIM_W:0]   trial;
    logic             fits;

    assign trial    = {rem_reg, quo_reg[DIV_N-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIM_W'(trial - {1'b0, dvs_reg}) : trial[DIM_W-1:0];
            quo_next = {quo_reg[DIV_N-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

@@ hw/rtl/mpc_core.sv @@
// ----------------------------------------------------------------------------
// mpc_core
// Sequencer around one shared 32x32 multiplier: maps the pixel to c and runs
// the escape-time iteration.
// ----------------------------------------------------------------------------
module mpc_core
    import mpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [IDX_W-1:0] in_column,
    input  logic [IDX_W-1:0] in_row,
    output logic             res_valid,
    input  logic             res_ready,
    output pix_t             res,
    output logic             div_start,
    output logic [DIV_N-1:0] div_dividend,
    output logic [DIM_W-1:0] div_divisor,
    input  logic             div_done,
    input  logic [DIV_N-1:0] div_quotient
);

    localparam logic signed [COORD_W-1:0] BOUND   = COORD_W'(64'sd1 <<< (FRAC_BITS + 1));
    localparam logic signed [PROD_W-1:0]  FOUR_SQ = PROD_W'(64'sd4 <<< (2 * FRAC_BITS));
    localparam logic signed [PROD_W-1:0]  C_MAX   = PROD_W'((64'sd1 <<< (COORD_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0]  C_MIN   = -C_MAX - 1;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > C_MAX)
            r = C_MAX[COORD_W-1:0];
        else if (v < C_MIN)
            r = C_MIN[COORD_W-1:0];
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    state_t                    state_reg;
    state_t                    state_next;
    logic                      axis_reg;
    logic                      axis_next;
    logic [IDX_W-1:0]          col_reg;
    logic [IDX_W-1:0]          col_next;
    logic [IDX_W-1:0]          row_reg;
    logic [IDX_W-1:0]          row_next;
    logic signed [COORD_W-1:0] cr_reg;
    logic signed [COORD_W-1:0] cr_next;
    logic signed [COORD_W-1:0] ci_reg;
    logic signed [COORD_W-1:0] ci_next;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] x_next;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [COORD_W-1:0] y_next;
    logic signed [PROD_W-1:0]  xx_reg;
    logic signed [PROD_W-1:0]  xx_next;
    logic signed [PROD_W-1:0]  yy_reg;
    logic signed [PROD_W-1:0]  yy_next;
    logic signed [PROD_W-1:0]  xy_reg;
    logic signed [PROD_W-1:0]  xy_next;
    logic [ITER_W-1:0]         iter_reg;
    logic [ITER_W-1:0]         iter_next;
    logic [ITER_W-1:0]         count_reg;
    logic [ITER_W-1:0]         count_next;
    logic                      inside_reg;
    logic                      inside_next;

    logic signed [COORD_W-1:0] mul_a;
    logic signed [COORD_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [IDX_W-1:0]          map_idx;
    logic [SPAN_W-1:0]         map_span;
    logic [DIM_W-1:0]          map_dim;
    logic signed [COORD_W-1:0] map_org;
    logic signed [COORD_W-1:0] map_c;
    logic signed [PROD_W-1:0]  mag_sq;
    logic signed [PROD_W-1:0]  re_sum;
    logic signed [PROD_W-1:0]  im_sum;
    logic signed [COORD_W-1:0] x_new;
    logic signed [COORD_W-1:0] y_new;
    logic                      out_of_bound;
    logic [3*CH_W-1:0]         rgb;

    assign map_idx  = axis_reg ? row_reg : col_reg;
    assign map_span = axis_reg ? cfg.span_imag : cfg.span_real;
    assign map_dim  = axis_reg ? cfg.image_height : cfg.image_width;
    assign map_org  = axis_reg ? cfg.origin_imag : cfg.origin_real;

    always_comb
    begin
        if (map_dim == '0)
            div_divisor = DIM_W'(1);
        else if (map_dim > DIM_W'(MAX_DIM))
            div_divisor = DIM_W'(MAX_DIM);
        else
            div_divisor = map_dim;
    end

    assign div_dividend = xy_reg[DIV_N-1:0];
    assign map_c = sat_coord(PROD_W'(map_org) + $signed({{(PROD_W-DIV_N){1'b0}}, div_quotient}));

    always_comb
    begin
        case (state_reg)
            ST_MAP_MUL:
            begin
                mul_a = $signed({{(COORD_W-IDX_W){1'b0}}, map_idx});
                mul_b = $signed({{(COORD_W-SPAN_W){1'b0}}, map_span});
            end
            ST_SQX:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            ST_SQY:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign mag_sq = xx_reg + yy_reg;
    assign re_sum = ((xx_reg - yy_reg) >>> FRAC_BITS) + PROD_W'(cr_reg);
    assign im_sum = (xy_reg >>> (FRAC_BITS - 1)) + PROD_W'(ci_reg);
    assign x_new  = sat_coord(re_sum);
    assign y_new  = sat_coord(im_sum);
    assign out_of_bound = (x_new > BOUND) || (x_new < -BOUND) ||
                          (y_new > BOUND) || (y_new < -BOUND);

    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        cr_next     = cr_reg;
        ci_next     = ci_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        xx_next     = xx_reg;
        yy_next     = yy_reg;
        xy_next     = xy_reg;
        iter_next   = iter_reg;
        count_next  = count_reg;
        inside_next = inside_reg;
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    col_next   = in_column;
                    row_next   = in_row;
                    axis_next  = 1'b0;
                    state_next = ST_MAP_MUL;
                end
            end
            ST_MAP_MUL:
            begin
                xy_next    = mul_p;
                state_next = ST_MAP_START;
            end
            ST_MAP_START:
            begin
                div_start  = 1'b1;
                state_next = ST_MAP_WAIT;
            end
            ST_MAP_WAIT:
            begin
                if (div_done)
                begin
                    if (!axis_reg)
                    begin
                        cr_next    = map_c;
                        axis_next  = 1'b1;
                        state_next = ST_MAP_MUL;
                    end
                    else
                    begin
                        ci_next    = map_c;
                        x_next     = '0;
                        y_next     = '0;
                        iter_next  = '0;
                        state_next = ST_SQX;
                    end
                end
            end
            ST_SQX:
            begin
                xx_next    = mul_p;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                yy_next    = mul_p;
                state_next = ST_PXY;
            end
            ST_PXY:
            begin
                if (mag_sq > FOUR_SQ)
                begin
                    inside_next = 1'b0;
                    count_next  = iter_reg - 1'b1;
                    state_next  = ST_DONE;
                end
                else if (iter_reg == ITER_W'(MAX_ITER))
                begin
                    inside_next = 1'b1;
                    count_next  = '0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    xy_next    = mul_p;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (out_of_bound)
                begin
                    inside_next = 1'b0;
                    count_next  = iter_reg;
                    state_next  = ST_DONE;
                end
                else
                begin
                    x_next     = x_new;
                    y_next     = y_new;
                    iter_next  = iter_reg + 1'b1;
                    state_next = ST_SQX;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        axis_reg   <= axis_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        xx_reg     <= xx_next;
        yy_reg     <= yy_next;
        xy_reg     <= xy_next;
        iter_reg   <= iter_next;
        count_reg  <= count_next;
        inside_reg <= inside_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign rgb       = palette(count_reg[PAL_W-1:0]);

    always_comb
    begin
        res.alpha        = ALPHA_OPAQUE;
        res.inside_set   = inside_reg;
        res.escape_count = inside_reg ? '0 : ESC_W'(count_reg);
        res.red          = inside_reg ? '0 : rgb[3*CH_W-1:2*CH_W];
        res.green        = inside_reg ? '0 : rgb[2*CH_W-1:CH_W];
        res.blue         = inside_reg ? '0 : rgb[CH_W-1:0];
    end

endmodule

@@ hw/rtl/mandelbrot_pixel_color.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_pixel_color
// Each input word names one pixel (column, row); the block maps it into the
// window set over APB, runs z = z*z + c from zero for up to 500 steps in
// signed Q4.28 and returns one output word with the palette color, alpha 255,
// the inside flag and the escape step. A pixel takes one word at a time: the
// block maps both coordinates (one multiply and a serial division per axis),
// then iterates, with the single 32x32 multiplier forming x*x, y*y and x*y
// in turn before each update. The finished word sits in an output register,
// so the next pixel is taken while it waits.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_color
    import mpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // column, row
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata    // red, green, blue, alpha, inside_set,
                                                   // escape_count, zero pad
);

    cfg_t             cfg;
    pix_t             res;
    logic             res_valid;
    logic             res_ready;
    logic             div_start;
    logic [DIV_N-1:0] div_dividend;
    logic [DIM_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_N-1:0] div_quotient;
    logic             out_valid_reg;
    logic             out_valid_next;
    pix_t             out_reg;
    pix_t             out_next;

    mpc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mpc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    mpc_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_column    (s_axis_tdata[IDX_W-1:0]),
        .in_row       (s_axis_tdata[2*IDX_W-1:IDX_W]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_OUT_W - $bits(pix_t)){1'b0}}, out_reg};

`ifndef SYNTHESIS
    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_reg.inside_set |->
            (out_reg.red == '0 && out_reg.green == '0 && out_reg.blue == '0 &&
             out_reg.escape_count == '0))
        else $error("inside pixel not black with zero count");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_reg.alpha == ALPHA_OPAQUE)
        else $error("alpha not opaque");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !out_reg.inside_set |-> out_reg.escape_count < ESC_W'(MAX_ITER))
        else $error("escape count beyond iteration limit");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while pixel in progress");
`endif

endmodule
